FILE: sv/diff_drive_odometry_defines.svh
// ---------------------------------------------------------------------------
// diff_drive_odometry_defines.svh
// Assertion macros shared by the odometry block.
// ---------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define DDO_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("odometry assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define DDO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("odometry assertion failed");

`endif

FILE: sv/ddo_pkg.sv
// ---------------------------------------------------------------------------
// ddo_pkg
// Types, constants and helper functions of the wheel odometry block.
// ---------------------------------------------------------------------------
package ddo_pkg;

  localparam int DIV_W = 64;
  localparam int MUL_W = 33;
  localparam int RAD_W = 45;
  localparam int ATAN_N = 24;

  localparam logic [30:0] PI_Q29      = 31'd1686629713;
  localparam logic [29:0] INV2PI_Q32  = 30'd683565276;
  localparam logic [29:0] CORDIC_K_Q30 = 30'd652032874;
  localparam logic [9:0]  MS_PER_S    = 10'd1000;

  localparam logic [9:0]  DIAM_RESET  = 10'd80;
  localparam logic [11:0] TRACK_RESET = 12'd341;
  localparam logic [15:0] CPR_RESET   = 16'd494;

  localparam logic [1:0] REG_DIAM  = 2'd0;
  localparam logic [1:0] REG_TRACK = 2'd1;
  localparam logic [1:0] REG_CPR   = 2'd2;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD,
    OP_MUL_TL, OP_MUL_TR, OP_MUL_TP, OP_DIV_WHEEL, OP_WR_DL, OP_WR_DR,
    OP_DC, OP_DIV_RAD, OP_WR_RAD, OP_ANG,
    OP_CS0, OP_WR_CS0, OP_CS1, OP_WR_CS1,
    OP_MUL_SX, OP_WR_SX, OP_MUL_SY, OP_WR_SY,
    OP_MUL_AX, OP_MUL_AY, OP_DIV_ARC, OP_WR_AX, OP_WR_AY,
    OP_POSE, OP_DIV_VX, OP_DIV_VY, OP_DIV_W, OP_WR_VX, OP_WR_VY, OP_WR_W,
    OP_OUT
  } op_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_MUL_L, ST_MULP_L, ST_DIV_L, ST_WAIT_L,
    ST_MUL_R, ST_MULP_R, ST_DIV_R, ST_WAIT_R,
    ST_DC, ST_DIV_RAD, ST_WAIT_RAD, ST_ANG,
    ST_CS0, ST_WAIT_CS0,
    ST_MUL_SX, ST_WR_SX, ST_MUL_SY, ST_WR_SY,
    ST_CS1, ST_WAIT_CS1,
    ST_MUL_AX, ST_DIV_AX, ST_WAIT_AX, ST_MUL_AY, ST_DIV_AY, ST_WAIT_AY,
    ST_POSE, ST_DIV_VX, ST_WAIT_VX, ST_DIV_VY, ST_WAIT_VY, ST_DIV_W, ST_WAIT_W,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic cs_done;
    logic rad_zero;
    logic ms_zero;
    logic out_busy;
  } status_t;

  // Round to nearest, ties away from zero, then shift right.
  function automatic logic signed [65:0] rnd_shr(input logic signed [65:0] v,
                                                 input int unsigned s);
    logic [65:0] m;
    m = v[65] ? 66'(-v) : 66'(v);
    m = (m + (66'd1 << (s - 1))) >> s;
    return v[65] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (!v[65] && (|v[64:31]))
      r = 32'sh7FFF_FFFF;
    else if (v[65] && !(&v[64:31]))
      r = 32'sh8000_0000;
    else
      r = v[31:0];
    return r;
  endfunction

  // Arctangent of 2^-i as a fraction of a turn, Q32.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/ddo_in_if.sv
// ---------------------------------------------------------------------------
// ddo_in_if
// Encoder interval channel: ticks per wheel and interval length.
// ---------------------------------------------------------------------------
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_ticks;
  logic signed [15:0] right_ticks;
  logic        [15:0] interval_ms;

  modport source (output valid, left_ticks, right_ticks, interval_ms, input ready);
  modport sink   (input valid, left_ticks, right_ticks, interval_ms, output ready);
endinterface

FILE: sv/ddo_out_if.sv
// ---------------------------------------------------------------------------
// ddo_out_if
// Pose and velocity result channel.
// ---------------------------------------------------------------------------
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] yaw_rate;
  logic               zero_interval;

  modport source (output valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                  zero_interval, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,
                  zero_interval, output ready);
endinterface

FILE: sv/ddo_cfg_if.sv
// ---------------------------------------------------------------------------
// ddo_cfg_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface ddo_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/diff_drive_odometry.sv
// ---------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: pose and velocity from encoder ticks.
//
//   channel  dir  payload                                        transaction
//   in_ch    in   left_ticks, right_ticks, interval_ms           valid & ready
//   out_ch   out  pos_x, pos_y, heading, vel_x, vel_y, yaw_rate,  valid & ready
//                 zero_interval
//   cfg_ch   in   index, data                                    valid & ready
//
// The 64-step divider, run up to eight times an update, and the CORDIC set
// how long an update takes; a straight step skips two divider calls and a
// zero interval three more, and the CORDIC runs once or twice an update.
// Synchronous active-low reset returns the pose to zero and the registers
// to their defaults. A result waits in the output register while the next
// transaction is taken; the block stalls only at its end if it is still held.
// ---------------------------------------------------------------------------
`include "diff_drive_odometry_defines.svh"

module diff_drive_odometry #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic          clk,
  input logic          rst_n,
  ddo_in_if.sink       in_ch,
  ddo_out_if.source    out_ch,
  ddo_cfg_if.sink      cfg_ch
);
  import ddo_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign cfg_ch.ready = 1'b1;

  ddo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ddo_datapath #(
    .ANGLE_BITS   (ANGLE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_ch.valid && cfg_ch.ready),
    .cfg_idx       (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .left_ticks    (in_ch.left_ticks),
    .right_ticks   (in_ch.right_ticks),
    .interval_ms   (in_ch.interval_ms),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .pos_x         (out_ch.pos_x),
    .pos_y         (out_ch.pos_y),
    .heading       (out_ch.heading),
    .vel_x         (out_ch.vel_x),
    .vel_y         (out_ch.vel_y),
    .yaw_rate      (out_ch.yaw_rate),
    .zero_interval (out_ch.zero_interval)
  );

  `DDO_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `DDO_ASSERT_SAME(a_load_on_accept, cmd.op == OP_LOAD, in_ch.valid && in_ch.ready)
  `DDO_ASSERT_SAME(a_zero_vel, out_ch.valid && out_ch.zero_interval, (out_ch.vel_x == 32'sd0) && (out_ch.vel_y == 32'sd0) && (out_ch.yaw_rate == 32'sd0))
endmodule

FILE: sv/ddo_div.sv
// ---------------------------------------------------------------------------
// ddo_div
// Radix-2 restoring divider, unsigned, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ddo_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ddo_pkg::DIV_W-1:0] num,
  input  logic [ddo_pkg::DIV_W-1:0] den,
  output logic                      done,
  output logic [ddo_pkg::DIV_W-1:0] quo
);
  import ddo_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [DIV_W-1:0] den_r, den_nxt;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W+1:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_sh   = {rem_r, quo_r[DIV_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, den_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      // keep the trial difference when it does not go negative
      if (!diff[DIV_W+1]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

FILE: sv/ddo_cordic.sv
// ---------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: sine and cosine of a binary angle.
// ---------------------------------------------------------------------------
module ddo_cordic #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ANGLE_BITS-1:0]       ang,
  output logic                        done,
  output logic signed [FRAC_BITS+1:0] sin_o,
  output logic signed [FRAC_BITS+1:0] cos_o
);
  import ddo_pkg::*;

  localparam int STEPS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
  localparam int IW    = $clog2(STEPS);
  localparam int CS_W  = FRAC_BITS + 2;

  logic          busy_r, rnd_r, done_r;
  logic [IW-1:0] cnt_r;
  logic          flip_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic signed [33:0] x_n, y_n, z_n, xs, ys, at;
  logic signed [CS_W-1:0] sin_r, cos_r;
  logic [31:0] u, u2;
  logic        flip;
  logic signed [65:0] xf, yf, xq, yq;

  always_comb begin
    u    = 32'(ang) << (32 - ANGLE_BITS);
    // fold the left half-plane onto the right
    flip = (u + 32'h4000_0000) >= 32'h8000_0000;
    u2   = flip ? u + 32'h8000_0000 : u;
    xs   = x_r >>> cnt_r;
    ys   = y_r >>> cnt_r;
    at   = $signed({2'b00, atan_turn(5'(cnt_r))});
    if (!z_r[33]) begin
      x_n = x_r - ys;
      y_n = y_r + xs;
      z_n = z_r - at;
    end else begin
      x_n = x_r + ys;
      y_n = y_r - xs;
      z_n = z_r + at;
    end
    xf = flip_r ? -x_r : x_r;
    yf = flip_r ? -y_r : y_r;
    xq = rnd_shr(xf, 30 - FRAC_BITS);
    yq = rnd_shr(yf, 30 - FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == IW'(STEPS - 1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= $signed({4'b0000, CORDIC_K_Q30});
      y_r    <= '0;
      z_r    <= $signed({{2{u2[31]}}, u2});
      flip_r <= flip;
    end else if (busy_r) begin
      x_r <= x_n;
      y_r <= y_n;
      z_r <= z_n;
    end
    if (rnd_r) begin
      cos_r <= xq[CS_W-1:0];
      sin_r <= yq[CS_W-1:0];
    end
  end

  assign done  = done_r;
  assign sin_o = sin_r;
  assign cos_o = cos_r;
endmodule

FILE: sv/ddo_datapath.sv
// ---------------------------------------------------------------------------
// ddo_datapath
// Pose registers, shared multiplier, divider and CORDIC, result register.
// ---------------------------------------------------------------------------
module ddo_datapath #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ddo_pkg::cmd_t      cmd,
  output ddo_pkg::status_t   sts,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [15:0]        cfg_data,
  input  logic signed [15:0] left_ticks,
  input  logic signed [15:0] right_ticks,
  input  logic [15:0]        interval_ms,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [15:0]        heading,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic signed [31:0] yaw_rate,
  output logic               zero_interval
);
  import ddo_pkg::*;

  localparam int CS_W = FRAC_BITS + 2;

  // configuration and pose
  logic [9:0]  diam_r;
  logic [11:0] track_r;
  logic [15:0] cpr_r;
  logic signed [31:0] px_r, py_r;
  logic [ANGLE_BITS-1:0] head_r;
  logic out_valid_r;

  // working registers
  logic signed [15:0] lt_r, rt_r;
  logic [15:0] ms_r;
  logic signed [65:0] mul_r;
  logic signed [31:0] dl_r, dr_r, dc_r, dx_r, dy_r, vx_r, vy_r, w_r;
  logic signed [RAD_W-1:0] rad_r;
  logic [ANGLE_BITS-1:0] h1_r;
  logic signed [CS_W-1:0] s0_r, c0_r, s1_r, c1_r;
  logic div_neg_r;

  // result register
  logic signed [31:0] o_px_r, o_py_r, o_vx_r, o_vy_r, o_w_r;
  logic [15:0] o_head_r;
  logic o_zero_r;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic mul_en;

  logic div_start, div_done;
  logic signed [65:0] div_n;
  logic [65:0] div_m;
  logic [DIV_W-1:0] div_d, div_num, quo;
  logic signed [65:0] qs;
  logic signed [31:0] q32;
  logic signed [65:0] q32_x, q32_neg;

  logic cs_start, cs_done;
  logic [ANGLE_BITS-1:0] cs_ang;
  logic signed [CS_W-1:0] cs_sin, cs_cos;

  logic [15:0] cpr_eff;
  logic [11:0] track_eff;
  logic [DIV_W-1:0] wheel_den;
  logic signed [32:0] ddiff, dsum;
  logic signed [65:0] ddiff_x, dsum_x, dx_x, dy_x, rad_x;
  logic [RAD_W-1:0] rad_mag;
  logic [79:0] a_hi, a_lo, a_t;
  logic [ANGLE_BITS-1:0] dang;
  logic signed [65:0] dc_rnd, sx_rnd, px_sum, py_sum;
  logic signed [CS_W:0] dsin, dcos;
  logic [ANGLE_BITS+15:0] hcat;

  always_comb begin
    cpr_eff   = (cpr_r == '0) ? 16'd1 : cpr_r;
    track_eff = (track_r == '0) ? 12'd1 : track_r;
    wheel_den = (64'(cpr_eff) * 64'(MS_PER_S)) << (29 - FRAC_BITS);
    ddiff     = dr_r - dl_r;
    dsum      = dl_r + dr_r;
    ddiff_x   = ddiff;
    dsum_x    = dsum;
    dx_x      = dx_r;
    dy_x      = dy_r;
    rad_x     = rad_r;
    rad_mag   = rad_r[RAD_W-1] ? RAD_W'(-rad_r) : RAD_W'(rad_r);
    dsin      = s1_r - s0_r;
    dcos      = c0_r - c1_r;
    dc_rnd    = rnd_shr(dsum_x, 1);
    sx_rnd    = rnd_shr(mul_r, FRAC_BITS);
    px_sum    = 66'(px_r) + dx_x;
    py_sum    = 66'(py_r) + dy_x;

    // radians to binary angle: whole radians and fraction scaled apart
    a_hi = 80'(rad_mag >> FRAC_BITS);
    a_lo = 80'(rad_mag[FRAC_BITS-1:0]);
    a_t  = a_hi * 80'(INV2PI_Q32)
         + ((a_lo * 80'(INV2PI_Q32) + (80'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    a_t  = (a_t + (80'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    dang = rad_r[RAD_W-1] ? ANGLE_BITS'(~a_t + 80'd1) : a_t[ANGLE_BITS-1:0];

    hcat = {head_r, 16'h0000};
  end

  // shared multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_MUL_TL: begin mul_a = lt_r; mul_b = $signed({23'd0, diam_r}); end
      OP_MUL_TR: begin mul_a = rt_r; mul_b = $signed({23'd0, diam_r}); end
      OP_MUL_TP: begin mul_a = mul_r[MUL_W-1:0]; mul_b = $signed({2'b00, PI_Q29}); end
      OP_MUL_SX: begin mul_a = dc_r; mul_b = c0_r; end
      OP_MUL_SY: begin mul_a = dc_r; mul_b = s0_r; end
      OP_MUL_AX: begin mul_a = dc_r; mul_b = dsin; end
      OP_MUL_AY: begin mul_a = dc_r; mul_b = dcos; end
      default:   mul_en = 1'b0;
    endcase
    mul_p = mul_a * mul_b;
  end

  // divider operand select; quotient rounds to nearest
  always_comb begin
    div_start = 1'b1;
    div_n     = '0;
    div_d     = 64'd1;
    case (cmd.op)
      OP_DIV_WHEEL: begin div_n = mul_r; div_d = wheel_den; end
      OP_DIV_RAD:   begin div_n = ddiff_x * 66'sd1000; div_d = 64'(track_eff); end
      OP_DIV_ARC:   begin div_n = mul_r; div_d = 64'(rad_mag); end
      OP_DIV_VX:    begin div_n = dx_x * 66'sd1000; div_d = 64'(ms_r); end
      OP_DIV_VY:    begin div_n = dy_x * 66'sd1000; div_d = 64'(ms_r); end
      OP_DIV_W:     begin div_n = rad_x * 66'sd1000; div_d = 64'(ms_r); end
      default:      div_start = 1'b0;
    endcase
    div_m   = div_n[65] ? 66'(-div_n) : 66'(div_n);
    div_num = div_m[DIV_W-1:0] + (div_d >> 1);
    qs      = div_neg_r ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    q32     = sat32(qs);
    q32_x   = q32;
    q32_neg = -q32_x;
  end

  assign cs_start = (cmd.op == OP_CS0) || (cmd.op == OP_CS1);
  assign cs_ang   = (cmd.op == OP_CS1) ? h1_r : head_r;

  ddo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_d),
    .done  (div_done),
    .quo   (quo)
  );

  ddo_cordic #(
    .ANGLE_BITS   (ANGLE_BITS),
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cs_start),
    .ang   (cs_ang),
    .done  (cs_done),
    .sin_o (cs_sin),
    .cos_o (cs_cos)
  );

  // control and state that reset clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r      <= DIAM_RESET;
      track_r     <= TRACK_RESET;
      cpr_r       <= CPR_RESET;
      px_r        <= '0;
      py_r        <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_DIAM:  diam_r  <= cfg_data[9:0];
          REG_TRACK: track_r <= cfg_data[11:0];
          REG_CPR:   cpr_r   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready)
        out_valid_r <= 1'b0;
      case (cmd.op)
        OP_POSE: begin
          px_r   <= sat32(px_sum);
          py_r   <= sat32(py_sum);
          head_r <= h1_r;
        end
        OP_OUT:  out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (mul_en)
      mul_r <= mul_p;
    if (div_start)
      div_neg_r <= div_n[65];
    case (cmd.op)
      OP_LOAD: begin
        lt_r <= left_ticks;
        rt_r <= right_ticks;
        ms_r <= interval_ms;
      end
      OP_WR_DL:  dl_r  <= q32;
      OP_WR_DR:  dr_r  <= q32;
      OP_DC:     dc_r  <= dc_rnd[31:0];
      OP_WR_RAD: rad_r <= qs[RAD_W-1:0];
      OP_ANG:    h1_r  <= head_r + dang;
      OP_WR_CS0: begin s0_r <= cs_sin; c0_r <= cs_cos; end
      OP_WR_CS1: begin s1_r <= cs_sin; c1_r <= cs_cos; end
      OP_WR_SX:  dx_r  <= sat32(sx_rnd);
      OP_WR_SY:  dy_r  <= sat32(sx_rnd);
      // a clockwise arc flips the sign after the first saturation
      OP_WR_AX:  dx_r  <= rad_r[RAD_W-1] ? sat32(q32_neg) : q32;
      OP_WR_AY:  dy_r  <= rad_r[RAD_W-1] ? sat32(q32_neg) : q32;
      OP_POSE: begin
        vx_r <= '0;
        vy_r <= '0;
        w_r  <= '0;
      end
      OP_WR_VX:  vx_r  <= q32;
      OP_WR_VY:  vy_r  <= q32;
      OP_WR_W:   w_r   <= q32;
      OP_OUT: begin
        o_px_r   <= px_r;
        o_py_r   <= py_r;
        o_head_r <= hcat[ANGLE_BITS+15 -: 16];
        o_vx_r   <= vx_r;
        o_vy_r   <= vy_r;
        o_w_r    <= w_r;
        o_zero_r <= (ms_r == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    sts.div_done = div_done;
    sts.cs_done  = cs_done;
    sts.rad_zero = (rad_r == '0);
    sts.ms_zero  = (ms_r == '0);
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid     = out_valid_r;
  assign pos_x         = o_px_r;
  assign pos_y         = o_py_r;
  assign heading       = o_head_r;
  assign vel_x         = o_vx_r;
  assign vel_y         = o_vy_r;
  assign yaw_rate      = o_w_r;
  assign zero_interval = o_zero_r;
endmodule

FILE: sv/ddo_ctrl.sv
// ---------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: steps the datapath through one odometry update.
// ---------------------------------------------------------------------------
module ddo_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  ddo_pkg::status_t sts,
  output ddo_pkg::cmd_t    cmd
);
  import ddo_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_MUL_L;
      ST_MUL_L:    state_nxt = ST_MULP_L;
      ST_MULP_L:   state_nxt = ST_DIV_L;
      ST_DIV_L:    state_nxt = ST_WAIT_L;
      ST_WAIT_L:   if (sts.div_done) state_nxt = ST_MUL_R;
      ST_MUL_R:    state_nxt = ST_MULP_R;
      ST_MULP_R:   state_nxt = ST_DIV_R;
      ST_DIV_R:    state_nxt = ST_WAIT_R;
      ST_WAIT_R:   if (sts.div_done) state_nxt = ST_DC;
      ST_DC:       state_nxt = ST_DIV_RAD;
      ST_DIV_RAD:  state_nxt = ST_WAIT_RAD;
      ST_WAIT_RAD: if (sts.div_done) state_nxt = ST_ANG;
      ST_ANG:      state_nxt = ST_CS0;
      ST_CS0:      state_nxt = ST_WAIT_CS0;
      ST_WAIT_CS0: if (sts.cs_done) state_nxt = sts.rad_zero ? ST_MUL_SX : ST_CS1;
      ST_MUL_SX:   state_nxt = ST_WR_SX;
      ST_WR_SX:    state_nxt = ST_MUL_SY;
      ST_MUL_SY:   state_nxt = ST_WR_SY;
      ST_WR_SY:    state_nxt = ST_POSE;
      ST_CS1:      state_nxt = ST_WAIT_CS1;
      ST_WAIT_CS1: if (sts.cs_done) state_nxt = ST_MUL_AX;
      ST_MUL_AX:   state_nxt = ST_DIV_AX;
      ST_DIV_AX:   state_nxt = ST_WAIT_AX;
      ST_WAIT_AX:  if (sts.div_done) state_nxt = ST_MUL_AY;
      ST_MUL_AY:   state_nxt = ST_DIV_AY;
      ST_DIV_AY:   state_nxt = ST_WAIT_AY;
      ST_WAIT_AY:  if (sts.div_done) state_nxt = ST_POSE;
      ST_POSE:     state_nxt = sts.ms_zero ? ST_OUT : ST_DIV_VX;
      ST_DIV_VX:   state_nxt = ST_WAIT_VX;
      ST_WAIT_VX:  if (sts.div_done) state_nxt = ST_DIV_VY;
      ST_DIV_VY:   state_nxt = ST_WAIT_VY;
      ST_WAIT_VY:  if (sts.div_done) state_nxt = ST_DIV_W;
      ST_DIV_W:    state_nxt = ST_WAIT_W;
      ST_WAIT_W:   if (sts.div_done) state_nxt = ST_OUT;
      ST_OUT:      if (!sts.out_busy) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE:     if (in_valid) cmd.op = OP_LOAD;
      ST_MUL_L:    cmd.op = OP_MUL_TL;
      ST_MULP_L:   cmd.op = OP_MUL_TP;
      ST_DIV_L:    cmd.op = OP_DIV_WHEEL;
      ST_WAIT_L:   if (sts.div_done) cmd.op = OP_WR_DL;
      ST_MUL_R:    cmd.op = OP_MUL_TR;
      ST_MULP_R:   cmd.op = OP_MUL_TP;
      ST_DIV_R:    cmd.op = OP_DIV_WHEEL;
      ST_WAIT_R:   if (sts.div_done) cmd.op = OP_WR_DR;
      ST_DC:       cmd.op = OP_DC;
      ST_DIV_RAD:  cmd.op = OP_DIV_RAD;
      ST_WAIT_RAD: if (sts.div_done) cmd.op = OP_WR_RAD;
      ST_ANG:      cmd.op = OP_ANG;
      ST_CS0:      cmd.op = OP_CS0;
      ST_WAIT_CS0: if (sts.cs_done) cmd.op = OP_WR_CS0;
      ST_MUL_SX:   cmd.op = OP_MUL_SX;
      ST_WR_SX:    cmd.op = OP_WR_SX;
      ST_MUL_SY:   cmd.op = OP_MUL_SY;
      ST_WR_SY:    cmd.op = OP_WR_SY;
      ST_CS1:      cmd.op = OP_CS1;
      ST_WAIT_CS1: if (sts.cs_done) cmd.op = OP_WR_CS1;
      ST_MUL_AX:   cmd.op = OP_MUL_AX;
      ST_DIV_AX:   cmd.op = OP_DIV_ARC;
      ST_WAIT_AX:  if (sts.div_done) cmd.op = OP_WR_AX;
      ST_MUL_AY:   cmd.op = OP_MUL_AY;
      ST_DIV_AY:   cmd.op = OP_DIV_ARC;
      ST_WAIT_AY:  if (sts.div_done) cmd.op = OP_WR_AY;
      ST_POSE:     cmd.op = OP_POSE;
      ST_DIV_VX:   cmd.op = OP_DIV_VX;
      ST_WAIT_VX:  if (sts.div_done) cmd.op = OP_WR_VX;
      ST_DIV_VY:   cmd.op = OP_DIV_VY;
      ST_WAIT_VY:  if (sts.div_done) cmd.op = OP_WR_VY;
      ST_DIV_W:    cmd.op = OP_DIV_W;
      ST_WAIT_W:   if (sts.div_done) cmd.op = OP_WR_W;
      // hold until the previous result has left the output register
      ST_OUT:      if (!sts.out_busy) cmd.op = OP_OUT;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      state_r <= ST_IDLE;
    else
      state_r <= state_nxt;
  end
endmodule
